[hw/rtl/svg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package svg_pkg;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_GATE  = 2'd2;
  // Unused request code: no-op with status ok
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // Gate codes
  localparam logic [2:0] G_H     = 3'd0;
  localparam logic [2:0] G_X     = 3'd1;
  localparam logic [2:0] G_Y     = 3'd2;
  localparam logic [2:0] G_Z     = 3'd3;
  localparam logic [2:0] G_PHASE = 3'd4;
  localparam logic [2:0] G_CNOT  = 3'd5;
  localparam logic [2:0] G_SWAP  = 3'd6;
  localparam logic [2:0] G_DIFF  = 3'd7;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_QUBIT = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  // sqrt(0.5) in Q1.15 and the rounding half of Q1.15
  localparam logic signed [15:0] INV_SQRT2_Q15 = 16'sd23170;
  localparam int Q15_HALF = 16384;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         gate;
    logic [3:0]         qubit_a;
    logic [3:0]         qubit_b;
    logic [3:0]         qubit_count;
    logic signed [15:0] phase_cos;
    logic signed [15:0] phase_sin;
    logic [9:0]         amp_index;
    logic signed [15:0] in_real;
    logic signed [15:0] in_imag;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_real;
    logic signed [15:0] out_imag;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDWAIT,
    S_SCAN,
    S_CAPA,
    S_CAPB,
    S_MUL,
    S_WRA,
    S_WRB,
    S_DSCAN,
    S_DSRD,
    S_DSACC,
    S_DWRD,
    S_DWR,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/svg_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module svg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/state_vector_gate_engine_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// State-vector gate engine: holds 2^num_qubits complex amplitudes in one RAM
// and runs write, read and gate words through a small sequencer around one
// shared multiplier.
// Input: a word is taken when start is high and busy is low; busy stays high
// until the result has been shown.
// Output: exactly one result word per input word, shown on out_data for one
// cycle with out_valid high. The receiver cannot stall, so nothing is held.
// Config: cfg_we writes num_qubits (cfg_data); write it only while idle.
// Sequencing: after the accepting edge a write or an error goes straight to
// DONE and a read passes through RDWAIT first; no new word is taken before then.
// A gate walks the index counter over all 2^n entries through the single RAM
// port pair: a SCAN step per skipped index, then for each touched element or
// pair: Z CAPA, WRA; X/Y/CNOT/SWAP CAPA, CAPB, WRA, WRB; phase CAPA, MUL, WRA;
// H CAPA, CAPB, MUL, WRA, WRB. Diffusion scans each index (DSCAN), sums each
// window (DSRD, DSACC), then writes each entry back (DWRD, DWR).
// Reset: state machine idle, num_qubits back to 10. RAM contents are
// undefined until written.
module state_vector_gate_engine_top #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH  = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire svg_pkg::in_word_t in_data,
  output logic                  out_valid,
  output svg_pkg::out_word_t    out_data,
  input  wire logic             cfg_we,
  input  wire logic [3:0]       cfg_data
);

  localparam int AW = MAX_QUBITS;
  localparam int W  = AMP_WIDTH;
  localparam int PW = W + 17;
  localparam int DW = W + AW;
  localparam int XW = W + AW + 20;
  localparam int QW = 5;
  localparam logic signed [XW-1:0] AMP_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] AMP_LO = ~AMP_HI;
  localparam logic signed [XW-1:0] O_HI   = XW'(32767);
  localparam logic signed [XW-1:0] O_LO   = ~O_HI;

  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    if (v > AMP_HI) r = AMP_HI;
    else if (v < AMP_LO) r = AMP_LO;
    else r = v;
    return r[W-1:0];
  endfunction

  function automatic logic signed [15:0] sat_o(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    if (v > O_HI) r = O_HI;
    else if (v < O_LO) r = O_LO;
    else r = v;
    return r[15:0];
  endfunction

  function automatic logic signed [W-1:0] rnd(input logic signed [XW-1:0] v);
    return sat_w((v + XW'(svg_pkg::Q15_HALF)) >>> 15);
  endfunction

  function automatic logic signed [W-1:0] neg(input logic signed [W-1:0] v);
    return sat_w(-XW'(v));
  endfunction

  svg_pkg::state_t    state_r, state_nxt;
  svg_pkg::in_word_t  op_r;
  svg_pkg::out_word_t res_r;
  logic [3:0]         nq_r;
  logic [AW:0]        cnt_r;
  logic [AW-1:0]      j_r;
  logic [1:0]         mstep_r;
  logic [2*W-1:0]     a_r, b_r;
  logic signed [PW-1:0] p_r [4];
  logic signed [DW-1:0] sum_re_r, sum_im_r;

  logic [QW-1:0]  nq_lim;
  logic [AW:0]    size;
  logic [AW-1:0]  idx, ba, bb, addr_b, win, sub_m1, k;
  logic           cond, pair, at_end, j_last, accept, idx_ok;
  logic [1:0]     gate_st;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [2*W-1:0] mem_wdata, rdata, fa, fb, dwr;
  logic signed [W-1:0] ra, ia, rb, ib, rd_re, rd_im;
  logic signed [W:0]   mx;
  logic signed [15:0]  my;
  logic signed [PW-1:0] prod;
  logic signed [XW-1:0] mean_re, mean_im;

  svg_ram #(.WIDTH(2 * W), .DEPTH(2 ** AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // Derive sizes, masks and addresses of the current step
  always_comb begin
    nq_lim = (QW'(nq_r) > QW'(AW)) ? QW'(AW) : QW'(nq_r);
    size   = (AW+1)'(1) << nq_lim;
    idx    = cnt_r[AW-1:0];
    at_end = (cnt_r == size);
    ba     = AW'(1) << op_r.qubit_a;
    bb     = AW'(1) << op_r.qubit_b;
    sub_m1 = (AW'(1) << op_r.qubit_count) - AW'(1);
    win    = sub_m1 << op_r.qubit_a;
    k      = idx | (j_r << op_r.qubit_a);
    j_last = (j_r == sub_m1);
    accept = start && !busy;
    idx_ok = 32'(in_data.amp_index) < 32'(size);
    ra = a_r[2*W-1:W];
    ia = a_r[W-1:0];
    rb = b_r[2*W-1:W];
    ib = b_r[W-1:0];
    rd_re = rdata[2*W-1:W];
    rd_im = rdata[W-1:0];
    pair = 1'b0;
    cond = 1'b0;
    addr_b = idx | ba;
    unique case (op_r.gate)
      svg_pkg::G_H, svg_pkg::G_X, svg_pkg::G_Y: begin
        pair = 1'b1;
        cond = (idx & ba) == '0;
      end
      svg_pkg::G_Z, svg_pkg::G_PHASE: begin
        cond = (idx & ba) != '0;
      end
      svg_pkg::G_CNOT: begin
        pair = 1'b1;
        cond = ((idx & ba) != '0) && ((idx & bb) == '0);
        addr_b = idx | bb;
      end
      svg_pkg::G_SWAP: begin
        pair = 1'b1;
        cond = ((idx & ba) != '0) && ((idx & bb) == '0);
        addr_b = (idx & ~ba) | bb;
      end
      svg_pkg::G_DIFF: begin
        cond = 1'b0;
      end
    endcase
  end

  // Check a gate word before it runs
  always_comb begin
    logic [QW:0] qa, qb, qc, n;
    qa = (QW+1)'(in_data.qubit_a);
    qb = (QW+1)'(in_data.qubit_b);
    qc = (QW+1)'(in_data.qubit_count);
    n  = (QW+1)'(nq_lim);
    gate_st = svg_pkg::ST_OK;
    if (qa >= n) begin
      gate_st = svg_pkg::ST_BAD_QUBIT;
    end else if ((in_data.gate == svg_pkg::G_CNOT || in_data.gate == svg_pkg::G_SWAP)
                 && qb >= n) begin
      gate_st = svg_pkg::ST_BAD_QUBIT;
    end else if (in_data.gate == svg_pkg::G_DIFF && (qc == '0 || qa + qc > n)) begin
      gate_st = svg_pkg::ST_BAD_QUBIT;
    end
  end

  // Select multiplier operands for the current step
  always_comb begin
    if (op_r.gate == svg_pkg::G_H) begin
      my = svg_pkg::INV_SQRT2_Q15;
      unique case (mstep_r)
        2'd0: mx = (W+1)'(ra) + (W+1)'(rb);
        2'd1: mx = (W+1)'(ia) + (W+1)'(ib);
        2'd2: mx = (W+1)'(ra) - (W+1)'(rb);
        2'd3: mx = (W+1)'(ia) - (W+1)'(ib);
      endcase
    end else begin
      mx = (mstep_r[0]) ? (W+1)'(ia) : (W+1)'(ra);
      my = (mstep_r == 2'd0 || mstep_r == 2'd3) ? op_r.phase_cos : op_r.phase_sin;
    end
    prod = PW'(mx) * PW'(my);
  end

  // Form write data for both entries of the step
  always_comb begin
    fa = b_r;
    fb = a_r;
    unique case (op_r.gate)
      svg_pkg::G_H: begin
        fa = {rnd(XW'(p_r[0])), rnd(XW'(p_r[1]))};
        fb = {rnd(XW'(p_r[2])), rnd(XW'(p_r[3]))};
      end
      svg_pkg::G_Y: begin
        fa = {ib, neg(rb)};
        fb = {neg(ia), ra};
      end
      svg_pkg::G_Z: begin
        fa = {neg(ra), neg(ia)};
      end
      svg_pkg::G_PHASE: begin
        fa = {rnd(XW'(p_r[0]) - XW'(p_r[1])), rnd(XW'(p_r[2]) + XW'(p_r[3]))};
      end
      svg_pkg::G_X, svg_pkg::G_CNOT, svg_pkg::G_SWAP, svg_pkg::G_DIFF: begin
        fa = b_r;
        fb = a_r;
      end
    endcase
    mean_re = XW'(sum_re_r) >>> op_r.qubit_count;
    mean_im = XW'(sum_im_r) >>> op_r.qubit_count;
    dwr = {sat_w((mean_re <<< 1) - XW'(rd_re)), sat_w((mean_im <<< 1) - XW'(rd_im))};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      svg_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == svg_pkg::REQ_READ && idx_ok) begin
            state_nxt = svg_pkg::S_RDWAIT;
          end else if (in_data.req_type == svg_pkg::REQ_GATE && gate_st == svg_pkg::ST_OK) begin
            state_nxt = (in_data.gate == svg_pkg::G_DIFF) ? svg_pkg::S_DSCAN : svg_pkg::S_SCAN;
          end else begin
            state_nxt = svg_pkg::S_DONE;
          end
        end
      end
      svg_pkg::S_RDWAIT: state_nxt = svg_pkg::S_DONE;
      svg_pkg::S_SCAN: begin
        if (at_end) state_nxt = svg_pkg::S_DONE;
        else if (cond) state_nxt = svg_pkg::S_CAPA;
      end
      svg_pkg::S_CAPA: begin
        if (pair) state_nxt = svg_pkg::S_CAPB;
        else if (op_r.gate == svg_pkg::G_PHASE) state_nxt = svg_pkg::S_MUL;
        else state_nxt = svg_pkg::S_WRA;
      end
      svg_pkg::S_CAPB: begin
        state_nxt = (op_r.gate == svg_pkg::G_H) ? svg_pkg::S_MUL : svg_pkg::S_WRA;
      end
      svg_pkg::S_MUL: begin
        if (mstep_r == 2'd3) state_nxt = svg_pkg::S_WRA;
      end
      svg_pkg::S_WRA: state_nxt = pair ? svg_pkg::S_WRB : svg_pkg::S_SCAN;
      svg_pkg::S_WRB: state_nxt = svg_pkg::S_SCAN;
      svg_pkg::S_DSCAN: begin
        if (at_end) state_nxt = svg_pkg::S_DONE;
        else if ((idx & win) == '0) state_nxt = svg_pkg::S_DSRD;
      end
      svg_pkg::S_DSRD: state_nxt = svg_pkg::S_DSACC;
      svg_pkg::S_DSACC: state_nxt = j_last ? svg_pkg::S_DWRD : svg_pkg::S_DSRD;
      svg_pkg::S_DWRD: state_nxt = svg_pkg::S_DWR;
      svg_pkg::S_DWR: state_nxt = j_last ? svg_pkg::S_DSCAN : svg_pkg::S_DWRD;
      svg_pkg::S_DONE: state_nxt = svg_pkg::S_IDLE;
      default: state_nxt = svg_pkg::S_IDLE;
    endcase
  end

  // Drive RAM ports and handshake outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = fa;
    mem_raddr = idx;
    busy      = (state_r != svg_pkg::S_IDLE);
    out_valid = (state_r == svg_pkg::S_DONE);
    out_data  = res_r;
    unique case (state_r)
      svg_pkg::S_IDLE: begin
        mem_raddr = AW'(in_data.amp_index);
        mem_waddr = AW'(in_data.amp_index);
        mem_wdata = {sat_w(XW'(in_data.in_real)), sat_w(XW'(in_data.in_imag))};
        mem_we    = accept && in_data.req_type == svg_pkg::REQ_WRITE && idx_ok;
      end
      svg_pkg::S_CAPA: mem_raddr = addr_b;
      svg_pkg::S_DSRD, svg_pkg::S_DWRD: mem_raddr = k;
      svg_pkg::S_WRA: mem_we = 1'b1;
      svg_pkg::S_WRB: begin
        mem_we    = 1'b1;
        mem_waddr = addr_b;
        mem_wdata = fb;
      end
      svg_pkg::S_DWR: begin
        mem_we    = 1'b1;
        mem_waddr = k;
        mem_wdata = dwr;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Control state and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svg_pkg::S_IDLE;
      nq_r    <= 4'd10;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) nq_r <= cfg_data;
    end
  end

  // Datapath registers, advanced per state
  always_ff @(posedge clk) begin
    unique case (state_r)
      svg_pkg::S_IDLE: begin
        if (accept) begin
          op_r           <= in_data;
          cnt_r          <= '0;
          j_r            <= '0;
          res_r.out_real <= '0;
          res_r.out_imag <= '0;
          if ((in_data.req_type == svg_pkg::REQ_WRITE || in_data.req_type == svg_pkg::REQ_READ)
              && !idx_ok) begin
            res_r.status <= svg_pkg::ST_BAD_INDEX;
          end else if (in_data.req_type == svg_pkg::REQ_GATE) begin
            res_r.status <= gate_st;
          end else begin
            res_r.status <= svg_pkg::ST_OK;
          end
        end
      end
      svg_pkg::S_RDWAIT: begin
        res_r.out_real <= sat_o(XW'(rd_re));
        res_r.out_imag <= sat_o(XW'(rd_im));
      end
      svg_pkg::S_SCAN: begin
        if (!at_end && !cond) cnt_r <= cnt_r + (AW+1)'(1);
      end
      svg_pkg::S_CAPA: begin
        a_r     <= rdata;
        mstep_r <= '0;
      end
      svg_pkg::S_CAPB: b_r <= rdata;
      svg_pkg::S_MUL: begin
        p_r[mstep_r] <= prod;
        mstep_r      <= mstep_r + 2'd1;
      end
      svg_pkg::S_WRA: begin
        if (!pair) cnt_r <= cnt_r + (AW+1)'(1);
      end
      svg_pkg::S_WRB: cnt_r <= cnt_r + (AW+1)'(1);
      svg_pkg::S_DSCAN: begin
        if (!at_end && (idx & win) != '0) cnt_r <= cnt_r + (AW+1)'(1);
        j_r      <= '0;
        sum_re_r <= '0;
        sum_im_r <= '0;
      end
      svg_pkg::S_DSACC: begin
        sum_re_r <= sum_re_r + DW'(rd_re);
        sum_im_r <= sum_im_r + DW'(rd_im);
        j_r      <= j_last ? '0 : j_r + AW'(1);
      end
      svg_pkg::S_DWR: begin
        if (j_last) begin
          j_r   <= '0;
          cnt_r <= cnt_r + (AW+1)'(1);
        end else begin
          j_r <= j_r + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[bench/tb_state_vector_gate_engine_top.sv]
`timescale 1ns / 1ps
module tb_state_vector_gate_engine_top;

  localparam int RUN_LIMIT = 3000000;
  localparam int DEPTH     = 1024;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  svg_pkg::in_word_t  in_data;
  logic               out_valid;
  svg_pkg::out_word_t out_data;
  logic               cfg_we;
  logic [3:0]         cfg_data;

  state_vector_gate_engine_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Shadow of the amplitude store and the qubit register
  longint    amp_re [DEPTH];
  longint    amp_im [DEPTH];
  bit        amp_set [DEPTH];
  int        active_qubits;
  svg_pkg::out_word_t pending_results[$];
  int        mismatches;
  int        cycle_count;
  int        sender_idle_pct;

  always #10 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Compare each result word with the oldest expected word
  always @(posedge clk) begin
    svg_pkg::out_word_t exp_w;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        exp_w = pending_results.pop_front();
        if (out_data.out_real !== exp_w.out_real)
          report_mismatch($sformatf("out_real %0d, expected %0d",
                                    out_data.out_real, exp_w.out_real));
        if (out_data.out_imag !== exp_w.out_imag)
          report_mismatch($sformatf("out_imag %0d, expected %0d",
                                    out_data.out_imag, exp_w.out_imag));
        if (out_data.status !== exp_w.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data.status, exp_w.status));
      end
    end
  end

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Round a Q1.15 product to nearest, ties upward
  function automatic longint round_q15(input longint v);
    return (v + svg_pkg::Q15_HALF) >>> 15;
  endfunction

  function automatic void swap_amps(input int a, input int b);
    longint r;
    longint m;
    r = amp_re[a]; m = amp_im[a];
    amp_re[a] = amp_re[b]; amp_im[a] = amp_im[b];
    amp_re[b] = r; amp_im[b] = m;
  endfunction

  function automatic void diffuse_window(input int size, input int first, input int cnt);
    int win;
    int sub;
    int k;
    longint sr;
    longint si;
    longint mr;
    longint mi;
    win = ((1 << cnt) - 1) << first;
    sub = 1 << cnt;
    for (int b = 0; b < size; b++) begin
      if ((b & win) != 0) continue;
      sr = 0; si = 0;
      for (int j = 0; j < sub; j++) begin
        k = b | (j << first);
        sr += amp_re[k]; si += amp_im[k];
      end
      mr = sr >>> cnt;
      mi = si >>> cnt;
      for (int j = 0; j < sub; j++) begin
        k = b | (j << first);
        amp_re[k] = clip16(2 * mr - amp_re[k]);
        amp_im[k] = clip16(2 * mi - amp_im[k]);
      end
    end
  endfunction

  // Apply one gate to the shadow vector; return its status
  function automatic logic [1:0] apply_gate(input svg_pkg::in_word_t w, input int n,
                                            input int size);
    int qa;
    int qb;
    int cnt;
    int ba;
    int bb;
    int j;
    longint pc;
    longint ps;
    longint r0;
    longint i0;
    longint r1;
    longint i1;
    qa = w.qubit_a; qb = w.qubit_b; cnt = w.qubit_count;
    pc = w.phase_cos; ps = w.phase_sin;
    if (qa >= n) return svg_pkg::ST_BAD_QUBIT;
    if ((w.gate == svg_pkg::G_CNOT || w.gate == svg_pkg::G_SWAP) && qb >= n)
      return svg_pkg::ST_BAD_QUBIT;
    if (w.gate == svg_pkg::G_DIFF) begin
      if (cnt == 0 || qa + cnt > n) return svg_pkg::ST_BAD_QUBIT;
      diffuse_window(size, qa, cnt);
      return svg_pkg::ST_OK;
    end
    ba = 1 << qa;
    bb = 1 << qb;
    for (int i = 0; i < size; i++) begin
      j = i | ba;
      r0 = amp_re[i]; i0 = amp_im[i];
      case (w.gate)
        svg_pkg::G_H: begin
          if ((i & ba) == 0) begin
            r1 = amp_re[j]; i1 = amp_im[j];
            amp_re[i] = clip16(round_q15((r0 + r1) * svg_pkg::INV_SQRT2_Q15));
            amp_im[i] = clip16(round_q15((i0 + i1) * svg_pkg::INV_SQRT2_Q15));
            amp_re[j] = clip16(round_q15((r0 - r1) * svg_pkg::INV_SQRT2_Q15));
            amp_im[j] = clip16(round_q15((i0 - i1) * svg_pkg::INV_SQRT2_Q15));
          end
        end
        svg_pkg::G_X: if ((i & ba) == 0) swap_amps(i, j);
        svg_pkg::G_Y: begin
          if ((i & ba) == 0) begin
            r1 = amp_re[j]; i1 = amp_im[j];
            amp_re[i] = clip16(i1);
            amp_im[i] = clip16(-r1);
            amp_re[j] = clip16(-i0);
            amp_im[j] = clip16(r0);
          end
        end
        svg_pkg::G_Z: begin
          if ((i & ba) != 0) begin
            amp_re[i] = clip16(-r0);
            amp_im[i] = clip16(-i0);
          end
        end
        svg_pkg::G_PHASE: begin
          if ((i & ba) != 0) begin
            amp_re[i] = clip16(round_q15(r0 * pc - i0 * ps));
            amp_im[i] = clip16(round_q15(r0 * ps + i0 * pc));
          end
        end
        svg_pkg::G_CNOT: if ((i & ba) != 0 && (i & bb) == 0) swap_amps(i, i | bb);
        default: if ((i & ba) != 0 && (i & bb) == 0) swap_amps(i, (i & ~ba) | bb);
      endcase
    end
    return svg_pkg::ST_OK;
  endfunction

  // Work out the result word of one accepted request
  function automatic svg_pkg::out_word_t predict_result(input svg_pkg::in_word_t w);
    svg_pkg::out_word_t r;
    int size;
    size = 1 << active_qubits;
    r = '0;
    if (w.req_type == svg_pkg::REQ_WRITE || w.req_type == svg_pkg::REQ_READ) begin
      if (w.amp_index >= size) begin
        r.status = svg_pkg::ST_BAD_INDEX;
      end else if (w.req_type == svg_pkg::REQ_WRITE) begin
        amp_re[w.amp_index] = w.in_real;
        amp_im[w.amp_index] = w.in_imag;
        amp_set[w.amp_index] = 1'b1;
      end else begin
        r.out_real = clip16(amp_re[w.amp_index]);
        r.out_imag = clip16(amp_im[w.amp_index]);
      end
    end else if (w.req_type == svg_pkg::REQ_GATE) begin
      r.status = apply_gate(w, active_qubits, size);
    end
    return r;
  endfunction

  function automatic svg_pkg::in_word_t make_word(input logic [1:0] req, input logic [2:0] g,
                                                  input int qa, input int qb, input int cnt,
                                                  input int idx, input int re, input int im);
    svg_pkg::in_word_t w;
    w.req_type = req; w.gate = g;
    w.qubit_a = qa; w.qubit_b = qb; w.qubit_count = cnt;
    w.phase_cos = $urandom; w.phase_sin = $urandom;
    w.amp_index = idx; w.in_real = re; w.in_imag = im;
    return w;
  endfunction

  // Hold start until the word is taken, then maybe idle
  task automatic send_word(input svg_pkg::in_word_t w);
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_result(w));
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 60 : 6)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every expected word has come back
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_qubits(input int v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_qubits = (v > 10) ? 10 : v;
  endtask

  // Write every active entry not yet written
  task automatic fill_vector;
    for (int i = 0; i < (1 << active_qubits); i++)
      if (!amp_set[i])
        send_word(make_word(svg_pkg::REQ_WRITE, svg_pkg::G_H, 0, 0, 0, i,
                            $urandom, $urandom));
  endtask

  function automatic svg_pkg::in_word_t random_word;
    svg_pkg::in_word_t w;
    int n;
    int size;
    n = active_qubits;
    size = 1 << n;
    w = make_word(svg_pkg::REQ_GATE, $urandom, 0, 0, 0, 0, $urandom, $urandom);
    case ($urandom_range(9))
      0, 1: w.req_type = svg_pkg::REQ_WRITE;
      2, 3: w.req_type = svg_pkg::REQ_READ;
      4: w.req_type = svg_pkg::REQ_NONE;
      default: w.req_type = svg_pkg::REQ_GATE;
    endcase
    if ($urandom_range(9) == 0) w.amp_index = $urandom;
    else w.amp_index = $urandom_range(size - 1);
    if ($urandom_range(7) == 0) begin
      w.qubit_a = $urandom; w.qubit_b = $urandom; w.qubit_count = $urandom;
    end else if (n > 0) begin
      w.qubit_a = $urandom_range(n - 1);
      w.qubit_b = $urandom_range(n - 1);
      w.qubit_count = $urandom_range(1, n - w.qubit_a);
    end
    if ($urandom_range(5) == 0) begin
      w.in_real = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      w.phase_cos = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end
    return w;
  endfunction

  // Every gate, every request type and the error cases on three qubits
  task automatic test_directed;
    logic [2:0] g;
    set_qubits(3);
    fill_vector();
    send_word(make_word(svg_pkg::REQ_WRITE, svg_pkg::G_H, 0, 0, 0, 7, -32768, 32767));
    send_word(make_word(svg_pkg::REQ_WRITE, svg_pkg::G_H, 0, 0, 0, 6, 32767, -32768));
    send_word(make_word(svg_pkg::REQ_READ, svg_pkg::G_H, 0, 0, 0, 7, 0, 0));
    for (int k = 0; k < 8; k++) begin
      g = k;
      send_word(make_word(svg_pkg::REQ_GATE, g, 2, 1, 2, 0, 0, 0));
      send_word(make_word(svg_pkg::REQ_READ, svg_pkg::G_H, 0, 0, 0, 6, 0, 0));
    end
    send_word(make_word(svg_pkg::REQ_GATE, svg_pkg::G_CNOT, 1, 1, 0, 0, 0, 0));
    send_word(make_word(svg_pkg::REQ_GATE, svg_pkg::G_SWAP, 0, 0, 0, 0, 0, 0));
    send_word(make_word(svg_pkg::REQ_GATE, svg_pkg::G_X, 15, 0, 0, 0, 0, 0));
    send_word(make_word(svg_pkg::REQ_GATE, svg_pkg::G_CNOT, 0, 3, 0, 0, 0, 0));
    send_word(make_word(svg_pkg::REQ_GATE, svg_pkg::G_DIFF, 0, 0, 0, 0, 0, 0));
    send_word(make_word(svg_pkg::REQ_GATE, svg_pkg::G_DIFF, 1, 0, 3, 0, 0, 0));
    send_word(make_word(svg_pkg::REQ_WRITE, svg_pkg::G_H, 0, 0, 0, 1023, 5, 5));
    send_word(make_word(svg_pkg::REQ_READ, svg_pkg::G_H, 0, 0, 0, 8, 0, 0));
    send_word(make_word(svg_pkg::REQ_NONE, svg_pkg::G_H, 0, 0, 0, 0, 0, 0));
  endtask

  // A one-entry vector: every gate is refused
  task automatic test_zero_qubits;
    set_qubits(0);
    fill_vector();
    send_word(make_word(svg_pkg::REQ_GATE, svg_pkg::G_Z, 0, 0, 1, 0, 0, 0));
    send_word(make_word(svg_pkg::REQ_READ, svg_pkg::G_H, 0, 0, 0, 0, 0, 0));
    send_word(make_word(svg_pkg::REQ_READ, svg_pkg::G_H, 0, 0, 0, 1, 0, 0));
  endtask

  // Register value above the maximum acts as the maximum
  task automatic test_full_size;
    set_qubits(15);
    send_word(make_word(svg_pkg::REQ_WRITE, svg_pkg::G_H, 0, 0, 0, 1023, 5, -7));
    send_word(make_word(svg_pkg::REQ_WRITE, svg_pkg::G_H, 0, 0, 0, 512, -32768, 32767));
    send_word(make_word(svg_pkg::REQ_READ, svg_pkg::G_H, 0, 0, 0, 1023, 0, 0));
    send_word(make_word(svg_pkg::REQ_GATE, svg_pkg::G_X, 10, 0, 0, 0, 0, 0));
    send_word(make_word(svg_pkg::REQ_GATE, svg_pkg::G_DIFF, 4, 0, 7, 0, 0, 0));
    send_word(make_word(svg_pkg::REQ_GATE, svg_pkg::G_CNOT, 3, 10, 0, 0, 0, 0));
    send_word(make_word(svg_pkg::REQ_READ, svg_pkg::G_H, 0, 0, 0, 512, 0, 0));
    set_qubits(10);
    send_word(make_word(svg_pkg::REQ_READ, svg_pkg::G_H, 0, 0, 0, 1023, 0, 0));
  endtask

  task automatic test_random(input int nq, input int idle_pct, input int count);
    set_qubits(nq);
    sender_idle_pct = idle_pct;
    fill_vector();
    for (int k = 0; k < count; k++) begin
      send_word(random_word());
      // hold off once until everything is back
      if (k == count / 2) drain();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    active_qubits = 10;
    for (int i = 0; i < DEPTH; i++) begin
      amp_re[i] = 0; amp_im[i] = 0; amp_set[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_zero_qubits();
    test_random(1, 0, 50);
    test_random(2, 72, 80);
    test_random(4, 21, 100);
    test_random(5, 0, 90);
    test_random(3, 72, 80);
    test_random(6, 21, 70);
    test_full_size();
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
